// ----- design/pcs_pkg.sv -----
// shared constants and codes for the priority counting semaphore
package pcs_pkg;

   // wait list geometry
   localparam int MAX_WAITERS = 16;
   localparam int PRIO_BITS   = 8;
   localparam int ID_W        = 4;
   localparam int ENTRY_W     = PRIO_BITS + ID_W;
   localparam int IDX_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int CNT_W       = $clog2(MAX_WAITERS + 1);

   // fixed field widths
   localparam int COUNT_W  = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
   localparam logic [CNT_W-1:0]   LIST_FULL   = CNT_W'(MAX_WAITERS);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_WAIT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TRYWAIT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POST    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_TAKEN    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_QUEUED   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_TRYFAIL  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_ABNORMAL = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_WOKE     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_INCR     = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_READ     = 3'd6;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd7;

   typedef logic [ENTRY_W-1:0] entry_type;

endpackage

// ----- design/priority_counting_semaphore_unit.sv -----
// top level of the priority counting semaphore with its sorted wait list
// take, try fail, abnormal, full, plain post, read and a wait onto an empty list
//   give their registered word in the next cycle after start is taken; busy stays low, a new word may follow
// a wait queued behind others and a waking post both walk the wait list ram one entry a cycle
//   with busy high, and give their word once the walk is done
// reset: synchronous, count loads 1 and the list empties; ram contents stay unknown
// the receiver cannot stall: rsp_strobe marks each result word for one cycle
module priority_counting_semaphore_unit
   import pcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request side
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ID_W-1:0]     req_task_id,
   input  logic [7:0]          req_task_prio,
   input  logic                req_task_suspended,
   // configuration
   input  logic                csr_write_en,
   input  logic [COUNT_W-1:0]  csr_write_data,
   // result side
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count_now,
   output logic                rsp_woken_valid,
   output logic [ID_W-1:0]     rsp_woken_task,
   output logic [TOTAL_W-1:0]  rsp_waiters_now
);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;  // ready for a request
   localparam logic [1:0] S_INS  = 2'd1;  // walk tail to head, shifting larger prios back
   localparam logic [1:0] S_PUT  = 2'd2;  // new waiter lands at the head
   localparam logic [1:0] S_DEQ  = 2'd3;  // pop head, shift the rest forward

   logic [1:0]           state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   entry_type            new_entry_ff, new_entry_in;
   logic [ID_W-1:0]      woken_ff, woken_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_wvalid_ff, rsp_wvalid_in;
   logic [ID_W-1:0]      rsp_wtask_ff, rsp_wtask_in;
   logic [TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;

   // wait list ram port signals
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   entry_type            ram_wr_data;
   logic [IDX_W-1:0]     ram_rd_addr;
   entry_type            ram_rd_data;

   logic [PRIO_BITS-1:0] req_prio;
   logic                 accept;
   logic                 shift_back;
   logic [CNT_W-1:0]     cur_next_wide;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   // all priority bits take part: PRIO_BITS matches the port width
   assign req_prio = PRIO_BITS'(req_task_prio);

   // the one shared compare: does the entry on the read port sort after the new waiter
   assign shift_back = (ram_rd_data[ENTRY_W-1:ID_W] > new_entry_ff[ENTRY_W-1:ID_W]);

   // next index in the forward walk, wide enough to reach the list total
   assign cur_next_wide = CNT_W'(cur_ff) + CNT_W'(1);

   pcs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_WAITERS)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      cur_in        = cur_ff;
      new_entry_in  = new_entry_ff;
      woken_in      = woken_ff;

      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_wvalid_in = 1'b0;
      rsp_wtask_in  = '0;
      rsp_total_in  = rsp_total_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               case (req_kind)
                  KIND_WAIT: begin
                     if (count_ff != '0) begin
                        count_in      = count_ff - COUNT_W'(1);
                        rsp_status_in = STAT_TAKEN;
                     end else if (req_task_suspended) begin
                        rsp_status_in = STAT_ABNORMAL;
                     end else if (total_ff >= LIST_FULL) begin
                        rsp_status_in = STAT_FULL;
                     end else if (total_ff == '0) begin
                        // empty list: the new waiter goes straight to the head
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = '0;
                        ram_wr_data   = {req_prio, req_task_id};
                        total_in      = CNT_W'(1);
                        rsp_status_in = STAT_QUEUED;
                     end else begin
                        // start the backward walk at the tail
                        rsp_strobe_in = 1'b0;
                        new_entry_in  = {req_prio, req_task_id};
                        cur_in        = IDX_W'(total_ff - CNT_W'(1));
                        ram_rd_addr   = IDX_W'(total_ff - CNT_W'(1));
                        state_in      = S_INS;
                     end
                  end
                  KIND_TRYWAIT: begin
                     if (count_ff != '0) begin
                        count_in      = count_ff - COUNT_W'(1);
                        rsp_status_in = STAT_TAKEN;
                     end else begin
                        rsp_status_in = STAT_TRYFAIL;
                     end
                  end
                  KIND_POST: begin
                     if (count_ff == '0 && total_ff != '0) begin
                        // fetch the head, the result follows the shift
                        rsp_strobe_in = 1'b0;
                        cur_in        = '0;
                        ram_rd_addr   = '0;
                        state_in      = S_DEQ;
                     end else begin
                        if (count_ff != COUNT_MAX) begin
                           count_in = count_ff + COUNT_W'(1);
                        end
                        rsp_status_in = STAT_INCR;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_READ;
                  end
               endcase
               rsp_count_in = count_in;
               rsp_total_in = TOTAL_W'(total_in);
            end
         end

         S_INS: begin
            if (shift_back) begin
               // move this entry one slot back
               ram_wr_en   = 1'b1;
               ram_wr_addr = cur_ff + IDX_W'(1);
               ram_wr_data = ram_rd_data;
               if (cur_ff == '0) begin
                  state_in = S_PUT;
               end else begin
                  cur_in      = cur_ff - IDX_W'(1);
                  ram_rd_addr = cur_ff - IDX_W'(1);
               end
            end else begin
               // equal or smaller prio stays ahead: fifo among equals
               ram_wr_en     = 1'b1;
               ram_wr_addr   = cur_ff + IDX_W'(1);
               ram_wr_data   = new_entry_ff;
               total_in      = total_ff + CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_QUEUED;
               rsp_count_in  = count_ff;
               rsp_total_in  = TOTAL_W'(total_in);
               state_in      = S_IDLE;
            end
         end

         S_PUT: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = '0;
            ram_wr_data   = new_entry_ff;
            total_in      = total_ff + CNT_W'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = STAT_QUEUED;
            rsp_count_in  = count_ff;
            rsp_total_in  = TOTAL_W'(total_in);
            state_in      = S_IDLE;
         end

         S_DEQ: begin
            if (cur_ff == '0) begin
               woken_in = ram_rd_data[ID_W-1:0];
            end else begin
               // shift this entry one slot forward
               ram_wr_en   = 1'b1;
               ram_wr_addr = cur_ff - IDX_W'(1);
               ram_wr_data = ram_rd_data;
            end
            if (cur_next_wide < total_ff) begin
               cur_in      = cur_ff + IDX_W'(1);
               ram_rd_addr = cur_ff + IDX_W'(1);
            end else begin
               total_in      = total_ff - CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_WOKE;
               rsp_count_in  = count_ff;
               rsp_wvalid_in = 1'b1;
               rsp_wtask_in  = (cur_ff == '0) ? ram_rd_data[ID_W-1:0] : woken_ff;
               rsp_total_in  = TOTAL_W'(total_in);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // init write reloads the count and drops the list
      if (csr_write_en) begin
         count_in = csr_write_data;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= COUNT_RESET;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      new_entry_ff  <= new_entry_in;
      woken_ff      <= woken_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_wvalid_ff <= rsp_wvalid_in;
      rsp_wtask_ff  <= rsp_wtask_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count_now   = rsp_count_ff;
   assign rsp_woken_valid = rsp_wvalid_ff;
   assign rsp_woken_task  = rsp_wtask_ff;
   assign rsp_waiters_now = rsp_total_ff;

endmodule

// ----- design/pcs_ram.sv -----
// generic single write, single read ram with registered read data
module pcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- verif/priority_counting_semaphore_unit_test.sv -----
// self-checking test of the priority counting semaphore: directed words, then random phases
module priority_counting_semaphore_unit_test;
   import pcs_pkg::*;

   // one request word as the sender keeps it
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
      logic [7:0]        prio;
      logic              susp;
      logic              after_drain;  // hold this word until every reply is back
   } op_word_type;

   // one reply word, laid out in port order
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                woken_valid;
      logic [ID_W-1:0]     woken_task;
      logic [TOTAL_W-1:0]  waiters;
   } sem_word_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side: every input to the block starts from a known value at time zero
   logic                start              = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind           = KIND_READ;
   logic [ID_W-1:0]     req_task_id        = '0;
   logic [7:0]          req_task_prio      = '0;
   logic                req_task_suspended = 1'b0;

   // count register port
   logic                csr_write_en   = 1'b0;
   logic [COUNT_W-1:0]  csr_write_data = '0;

   // reply side
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count_now;
   logic                rsp_woken_valid;
   logic [ID_W-1:0]     rsp_woken_task;
   logic [TOTAL_W-1:0]  rsp_waiters_now;

   // words still to send, and replies still owed by the block
   op_word_type  pending_ops[$];
   sem_word_type awaited_replies[$];
   op_word_type  in_flight;

   // our own view of the semaphore: unit count and the sorted wait list
   logic [COUNT_W-1:0]   sem_units;
   logic [PRIO_BITS-1:0] list_prio[MAX_WAITERS];
   logic [ID_W-1:0]      list_id[MAX_WAITERS];
   int                   list_len;

   // bookkeeping
   int send_idle_pct = 0;
   int queued_total  = 0;
   int sent_total    = 0;
   int fault_total   = 0;
   int load_total    = 0;
   int status_seen[8];

   priority_counting_semaphore_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_task_id        (req_task_id),
      .req_task_prio      (req_task_prio),
      .req_task_suspended (req_task_suspended),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_count_now      (rsp_count_now),
      .rsp_woken_valid    (rsp_woken_valid),
      .rsp_woken_task     (rsp_woken_task),
      .rsp_waiters_now    (rsp_waiters_now)
   );

   // 8 unit period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // apply one request to our semaphore view and return the reply it must give
   function automatic sem_word_type step_semaphore(input op_word_type op);
      sem_word_type         w;
      logic [PRIO_BITS-1:0] p;
      int                   pos;
      w = '0;
      p = op.prio[PRIO_BITS-1:0];
      case (op.kind)
         KIND_WAIT: begin
            if (sem_units != 0) begin
               sem_units--;
               w.status = STAT_TAKEN;
            end else if (op.susp) begin
               // already suspended and nothing free: refused, nothing moves
               w.status = STAT_ABNORMAL;
            end else if (list_len >= MAX_WAITERS) begin
               w.status = STAT_FULL;
            end else begin
               // behind every entry of equal or better priority
               pos = 0;
               while (pos < list_len && list_prio[pos] <= p) pos++;
               for (int j = list_len; j > pos; j--) begin
                  list_prio[j] = list_prio[j-1];
                  list_id[j]   = list_id[j-1];
               end
               list_prio[pos] = p;
               list_id[pos]   = op.id;
               list_len++;
               w.status = STAT_QUEUED;
            end
         end
         KIND_TRYWAIT: begin
            if (sem_units != 0) begin
               sem_units--;
               w.status = STAT_TAKEN;
            end else begin
               w.status = STAT_TRYFAIL;
            end
         end
         KIND_POST: begin
            if (sem_units == 0 && list_len > 0) begin
               // hand the unit straight to the head waiter
               w.woken_valid = 1'b1;
               w.woken_task  = list_id[0];
               for (int j = 0; j < list_len - 1; j++) begin
                  list_prio[j] = list_prio[j+1];
                  list_id[j]   = list_id[j+1];
               end
               list_len--;
               w.status = STAT_WOKE;
            end else begin
               // saturating increment
               if (sem_units != COUNT_MAX) sem_units++;
               w.status = STAT_INCR;
            end
         end
         default: begin
            w.status = STAT_READ;
         end
      endcase
      w.count   = sem_units;
      w.waiters = TOTAL_W'(list_len);
      return w;
   endfunction

   // driver: present the next word whenever the current one is gone or none is up
   always @(posedge clock) begin : drive_requests
      op_word_type nxt;
      logic        fire;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            awaited_replies.push_back(step_semaphore(in_flight));
            sent_total++;
         end
         if (!start || !busy) begin
            fire = 1'b0;
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               // a drain point waits until the block owes nothing
               if (!pending_ops[0].after_drain || awaited_replies.size() == 0) fire = 1'b1;
            end
            if (fire) begin
               nxt                = pending_ops.pop_front();
               in_flight          = nxt;
               req_kind           <= nxt.kind;
               req_task_id        <= nxt.id;
               req_task_prio      <= nxt.prio;
               req_task_suspended <= nxt.susp;
               start              <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed word against the oldest owed reply
   always @(posedge clock) begin : check_replies
      sem_word_type got;
      sem_word_type want;
      if (!reset && rsp_strobe) begin
         got = {rsp_status, rsp_count_now, rsp_woken_valid, rsp_woken_task, rsp_waiters_now};
         status_seen[got.status]++;
         if (awaited_replies.size() == 0) begin
            fault_total++;
            if (fault_total <= 10)
               $display("%0t: reply word with none owed: status %0d count %0d woken %0d/%0d",
                        $time, got.status, got.count, got.woken_valid, got.woken_task,
                        " waiters %0d", got.waiters);
         end else begin
            want = awaited_replies.pop_front();
            if (got != want) begin
               fault_total++;
               if (fault_total <= 10) begin
                  $write("%0t: reply mismatch: expected status %0d count %0d woken %0d/%0d",
                         $time, want.status, want.count, want.woken_valid, want.woken_task);
                  $write(" waiters %0d, got status %0d count %0d woken %0d/%0d",
                         want.waiters, got.status, got.count, got.woken_valid,
                         got.woken_task);
                  $display(" waiters %0d", got.waiters);
               end
            end
         end
      end
   end

   function automatic void add_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                  input logic [7:0] prio, input logic susp,
                                  input logic after_drain);
      op_word_type op;
      op.kind        = kind;
      op.id          = id;
      op.prio        = prio;
      op.susp        = susp;
      op.after_drain = after_drain;
      pending_ops.push_back(op);
      queued_total++;
   endfunction

   // priorities bunched on a few values so ties are common
   function automatic logic [7:0] pick_prio();
      if ($urandom_range(1) == 0) return 8'($urandom_range(3) * 85);
      return 8'($urandom_range(255));
   endfunction

   // any priority at all
   function automatic logic [7:0] any_prio();
      return 8'($urandom_range(255));
   endfunction

   // any task id
   function automatic logic [ID_W-1:0] pick_id();
      return ID_W'($urandom_range(15));
   endfunction

   // a coin flip
   function automatic logic pick_bit();
      return 1'($urandom_range(1));
   endfunction

   // random part: mostly wait/post contention on a zero count, plus noise
   function automatic void plan_random(input int n_items);
      int goal;
      int k;
      int n;
      bit first;
      goal  = queued_total + n_items;
      first = 1'b1;
      while (queued_total < goal) begin
         k     = first ? 45 : $urandom_range(99);
         first = 1'b0;
         if (k < 40) begin
            // soak up spare units, then waiters contend and get posted out
            repeat ($urandom_range(0, 3))
               add_op(KIND_TRYWAIT, pick_id(), any_prio(), pick_bit(), 1'b0);
            n = $urandom_range(1, 10);
            repeat (n)
               add_op(KIND_WAIT, pick_id(), pick_prio(), $urandom_range(19) == 0, 1'b0);
            repeat (n + $urandom_range(0, 1)) begin
               if ($urandom_range(4) == 0)
                  add_op($urandom_range(1) ? KIND_READ : KIND_TRYWAIT, pick_id(),
                         any_prio(), pick_bit(), 1'b0);
               add_op(KIND_POST, pick_id(), any_prio(), pick_bit(), 1'b0);
            end
         end else if (k < 55) begin
            // overfill the wait list, then drain it after a pause
            repeat ($urandom_range(0, 3))
               add_op(KIND_TRYWAIT, pick_id(), any_prio(), 1'b0, 1'b0);
            n = 16 + $urandom_range(0, 3);
            repeat (n)
               add_op(KIND_WAIT, pick_id(), pick_prio(), $urandom_range(9) == 0, 1'b0);
            add_op(KIND_READ, pick_id(), any_prio(), pick_bit(), 1'b0);
            add_op(KIND_POST, pick_id(), any_prio(), pick_bit(), 1'b1);
            repeat (n - 1)
               add_op(KIND_POST, pick_id(), any_prio(), pick_bit(), 1'b0);
         end else if (k < 75) begin
            // trywait and post ping-pong
            repeat ($urandom_range(2, 8))
               add_op($urandom_range(1) ? KIND_TRYWAIT : KIND_POST, pick_id(),
                      any_prio(), pick_bit(), 1'b0);
         end else begin
            // anything at all
            repeat ($urandom_range(1, 6))
               add_op(KIND_W'($urandom_range(3)), pick_id(), any_prio(), pick_bit(), 1'b0);
         end
      end
   endfunction

   // wait until every word is sent and answered and the block has gone quiet
   task automatic settle();
      int waited;
      waited = 0;
      while (sent_total != queued_total) @(posedge clock);
      while ((awaited_replies.size() != 0 || busy) && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (24) @(posedge clock);
   endtask

   // reload the count; the block also empties its wait list
   task automatic load_count(input logic [COUNT_W-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sem_units = value;
      list_len  = 0;
      load_total++;
   endtask

   initial begin
      sem_units = COUNT_RESET;
      list_len  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, count starts at one
      send_idle_pct = 21;
      add_op(KIND_READ,    4'd0,  8'd0,   1'b0, 1'b0);
      add_op(KIND_WAIT,    4'd1,  8'd255, 1'b1, 1'b0);  // suspended but a unit is free
      add_op(KIND_TRYWAIT, 4'd2,  8'd7,   1'b1, 1'b0);  // try fails at zero
      add_op(KIND_WAIT,    4'd4,  8'd9,   1'b1, 1'b0);  // abnormal wait
      add_op(KIND_WAIT,    4'd15, 8'd255, 1'b0, 1'b0);
      add_op(KIND_WAIT,    4'd0,  8'd0,   1'b0, 1'b0);  // jumps to the head
      add_op(KIND_WAIT,    4'd3,  8'd0,   1'b0, 1'b0);  // equal priority, fifo after id 0
      add_op(KIND_WAIT,    4'd15, 8'd128, 1'b0, 1'b0);  // same id queued twice
      add_op(KIND_READ,    4'd15, 8'd255, 1'b1, 1'b0);
      add_op(KIND_POST,    4'd5,  8'd0,   1'b0, 1'b1);  // pause until the block owes nothing
      add_op(KIND_POST,    4'd6,  8'd255, 1'b1, 1'b0);
      add_op(KIND_POST,    4'd7,  8'd1,   1'b0, 1'b0);
      add_op(KIND_POST,    4'd8,  8'd2,   1'b1, 1'b0);
      add_op(KIND_POST,    4'd9,  8'd3,   1'b0, 1'b0);  // list empty, count goes to one
      add_op(KIND_TRYWAIT, 4'd9,  8'd255, 1'b1, 1'b0);
      add_op(KIND_POST,    4'd15, 8'd255, 1'b1, 1'b0);
      add_op(KIND_READ,    4'd10, 8'd170, 1'b0, 1'b0);
      settle();

      // top of the count range
      load_count(COUNT_MAX);
      add_op(KIND_POST,    4'd0,  8'd0,   1'b0, 1'b0);  // saturates
      add_op(KIND_READ,    4'd1,  8'd1,   1'b0, 1'b0);
      add_op(KIND_TRYWAIT, 4'd2,  8'd2,   1'b0, 1'b0);
      add_op(KIND_POST,    4'd3,  8'd3,   1'b0, 1'b0);
      add_op(KIND_POST,    4'd4,  8'd4,   1'b0, 1'b0);
      settle();

      // random phases over several count loads
      load_count('0);
      send_idle_pct = 21;
      plan_random(300);
      settle();

      load_count(COUNT_W'(3));
      send_idle_pct = 85;
      plan_random(300);
      settle();

      load_count(COUNT_W'($urandom_range(1, 2)));
      send_idle_pct = 0;
      plan_random(250);
      settle();

      // replies that never came
      if (awaited_replies.size() != 0) begin
         fault_total += awaited_replies.size();
         $display("%0d reply words never arrived", awaited_replies.size());
      end

      $display("sent %0d request words across %0d count loads; taken %0d, queued %0d",
               sent_total, load_total, status_seen[STAT_TAKEN], status_seen[STAT_QUEUED]);
      $display("try failed %0d, abnormal %0d, woke %0d, incremented %0d, read %0d",
               status_seen[STAT_TRYFAIL], status_seen[STAT_ABNORMAL],
               status_seen[STAT_WOKE], status_seen[STAT_INCR], status_seen[STAT_READ]);
      $display("list full %0d, bad replies %0d", status_seen[STAT_FULL], fault_total);
      if (fault_total == 0) begin
         $display("priority_counting_semaphore_unit_test passed");
      end else begin
         $display("priority_counting_semaphore_unit_test failed");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #(400000 * 8);
      $display("priority_counting_semaphore_unit_test failed");
      $finish;
   end

endmodule
